// ===== design/ckbw_pkg.sv =====
// Package for the color-keyed blit writer: field widths, register codes,
// default screen geometry and the result record type.
// Depends on nothing; used by color_keyed_blit_writer.
package ckbw_pkg;

  // Default screen geometry and source row padding.
  localparam int SCREEN_COLUMNS_DEF = 640;
  localparam int SCREEN_ROWS_DEF    = 480;
  localparam int ROW_PAD_DEF        = 8;

  // Widths of the configuration registers and of the stream fields.
  localparam int ORIGIN_X_W    = 10;
  localparam int ORIGIN_Y_W    = 9;
  localparam int IMAGE_W_W     = 10;
  localparam int IMAGE_H_W     = 9;
  localparam int CFG_DATA_W    = 10;
  localparam int CFG_INDEX_W   = 2;
  localparam int PIXEL_W       = 32;
  localparam int FRAME_INDEX_W = 19;
  localparam int KEY_W         = 8;

  // Register values after reset.
  localparam logic [ORIGIN_X_W-1:0] ORIGIN_X_RST = '0;
  localparam logic [ORIGIN_Y_W-1:0] ORIGIN_Y_RST = '0;
  localparam logic [IMAGE_W_W-1:0]  IMAGE_W_RST  = 10'd8;
  localparam logic [IMAGE_H_W-1:0]  IMAGE_H_RST  = 9'd1;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ORIGIN_X     = 2'd0,
    REG_ORIGIN_Y     = 2'd1,
    REG_IMAGE_WIDTH  = 2'd2,
    REG_IMAGE_HEIGHT = 2'd3
  } cfg_reg_t;

  // One framebuffer write as it leaves the block.
  typedef struct packed {
    logic                     write_enable;
    logic [FRAME_INDEX_W-1:0] frame_index;
    logic [PIXEL_W-1:0]       pixel_out;
    logic                     rejected;
    logic                     last_pixel;
  } result_t;

endpackage

// ===== design/color_keyed_blit_writer.sv =====
// Color-keyed blit writer: walks a padded source image in row order and
// emits one framebuffer write per pixel. Depends on ckbw_pkg.
//
// Each result is registered into the output buffer when its pixel is accepted.
// Throughput: one pixel per cycle; the address is one constant multiply and
// add on the counters, and a two-entry output buffer keeps input and output
// apart so the input only stalls when both entries hold untaken results.
// Reset (rst, synchronous): counters to zero, registers to their defaults
// (origin 0,0, width 8, height 1), output buffer emptied.
module color_keyed_blit_writer #(
  parameter int SCREEN_COLUMNS = ckbw_pkg::SCREEN_COLUMNS_DEF,
  parameter int SCREEN_ROWS    = ckbw_pkg::SCREEN_ROWS_DEF,
  parameter int ROW_PAD        = ckbw_pkg::ROW_PAD_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration write port
  input  logic                                 cfg_write,
  input  logic [ckbw_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [ckbw_pkg::CFG_DATA_W-1:0]      cfg_data,
  // Source pixel channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [ckbw_pkg::PIXEL_W-1:0]         source_pixel,
  // Framebuffer write channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 write_enable,
  output logic [ckbw_pkg::FRAME_INDEX_W-1:0]   frame_index,
  output logic [ckbw_pkg::PIXEL_W-1:0]         pixel_out,
  output logic                                 rejected,
  output logic                                 last_pixel
);

  localparam int IDX_W   = ckbw_pkg::FRAME_INDEX_W;
  localparam int COL_W   = ckbw_pkg::IMAGE_W_W;
  localparam int ROW_W   = ckbw_pkg::IMAGE_H_W;
  localparam int PHASE_W = (ROW_PAD > 1) ? $clog2(ROW_PAD) : 1;
  // Width for the fit checks: room for the register sums and the screen size.
  localparam int XC_W = ($clog2(SCREEN_COLUMNS + 1) > COL_W + 1) ?
                        $clog2(SCREEN_COLUMNS + 1) : COL_W + 1;
  localparam int YC_W = ($clog2(SCREEN_ROWS + 1) > ROW_W + 1) ?
                        $clog2(SCREEN_ROWS + 1) : ROW_W + 1;

  // Configuration registers.
  logic [ckbw_pkg::ORIGIN_X_W-1:0] origin_x;
  logic [ckbw_pkg::ORIGIN_Y_W-1:0] origin_y;
  logic [ckbw_pkg::IMAGE_W_W-1:0]  image_width;
  logic [ckbw_pkg::IMAGE_H_W-1:0]  image_height;

  // Position counters; phase tracks column_count modulo ROW_PAD.
  logic [COL_W-1:0]   column_count, column_count_next;
  logic [ROW_W-1:0]   row_count, row_count_next;
  logic [PHASE_W-1:0] phase, phase_next;

  // Output buffer: head entry drives the ports, skid entry catches a stall.
  ckbw_pkg::result_t head, skid, result;
  logic              head_valid, skid_valid;

  logic             in_xfer, out_xfer;
  logic             empty_image, off_screen, row_end, last;
  logic [COL_W:0]   col_plus;
  logic [COL_W:0]   col_aligned;
  logic [PHASE_W-1:0] phase_plus;
  logic [ROW_W:0]   row_plus;
  logic [COL_W:0]   row_sum;

  assign in_stall = skid_valid;
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = head_valid && !out_stall;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x     <= ckbw_pkg::ORIGIN_X_RST;
      origin_y     <= ckbw_pkg::ORIGIN_Y_RST;
      image_width  <= ckbw_pkg::IMAGE_W_RST;
      image_height <= ckbw_pkg::IMAGE_H_RST;
    end else if (cfg_write) begin
      case (ckbw_pkg::cfg_reg_t'(cfg_index))
        ckbw_pkg::REG_ORIGIN_X:     origin_x     <= cfg_data[ckbw_pkg::ORIGIN_X_W-1:0];
        ckbw_pkg::REG_ORIGIN_Y:     origin_y     <= cfg_data[ckbw_pkg::ORIGIN_Y_W-1:0];
        ckbw_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data[ckbw_pkg::IMAGE_W_W-1:0];
        ckbw_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data[ckbw_pkg::IMAGE_H_W-1:0];
        default: ;
      endcase
    end
  end

  // Fit checks depend on the registers alone.
  always_comb begin
    empty_image = (image_width == '0) || (image_height == '0);
    off_screen  = empty_image
        || ((XC_W'(origin_x) + XC_W'(image_width)) > XC_W'(SCREEN_COLUMNS))
        || ((YC_W'(origin_y) + YC_W'(image_height)) > YC_W'(SCREEN_ROWS));
  end

  // Row end: the largest multiple of ROW_PAD not above column_count+1 has
  // reached the image width, which is the same as reaching the padded stride.
  always_comb begin
    col_plus    = {1'b0, column_count} + 1'b1;
    phase_plus  = (phase == PHASE_W'(ROW_PAD - 1)) ? '0 : phase + 1'b1;
    col_aligned = col_plus - (COL_W + 1)'(phase_plus);
    row_plus    = {1'b0, row_count} + 1'b1;
    row_end     = empty_image || (col_aligned >= (COL_W + 1)'(image_width));
    last        = empty_image || (row_end && (row_plus >= (ROW_W + 1)'(image_height)));
  end

  // Result for the pixel on the input port; the index wraps at its field width.
  always_comb begin
    row_sum = (COL_W + 1)'(origin_y) + (COL_W + 1)'(row_count);
    result.write_enable = (|source_pixel[ckbw_pkg::KEY_W-1:0]) && !off_screen;
    result.frame_index  = IDX_W'(SCREEN_COLUMNS) * IDX_W'(row_sum)
                          + IDX_W'(origin_x) + IDX_W'(column_count);
    result.pixel_out    = source_pixel;
    result.rejected     = off_screen;
    result.last_pixel   = last;
  end

  // Counter advance for an accepted pixel.
  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    phase_next        = phase;
    if (in_xfer) begin
      if (last) begin
        column_count_next = '0;
        row_count_next    = '0;
        phase_next        = '0;
      end else if (row_end) begin
        column_count_next = '0;
        row_count_next    = row_plus[ROW_W-1:0];
        phase_next        = '0;
      end else begin
        column_count_next = col_plus[COL_W-1:0];
        // A wrap of the column counter restarts the padding phase with it.
        phase_next        = col_plus[COL_W] ? '0 : phase_plus;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      phase        <= '0;
    end else begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
      phase        <= phase_next;
    end
  end

  // Two-entry output buffer: a new transfer lands in the head when it is
  // free or being taken, otherwise in the skid entry.
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (!head_valid || out_xfer) begin
        if (skid_valid) begin
          head_valid <= 1'b1;
          skid_valid <= 1'b0;
        end else begin
          head_valid <= in_xfer;
        end
      end else if (in_xfer) begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!head_valid || out_xfer) begin
      if (skid_valid) begin
        head <= skid;
      end else if (in_xfer) begin
        head <= result;
      end
    end else if (in_xfer) begin
      skid <= result;
    end
  end

  // Output ports.
  assign out_valid    = head_valid;
  assign write_enable = head.write_enable;
  assign frame_index  = head.frame_index;
  assign pixel_out    = head.pixel_out;
  assign rejected     = head.rejected;
  assign last_pixel   = head.last_pixel;

endmodule
